// ----- rtl/bss_pkg.sv -----
// Shared types for the subset-sum set core: command codes, result status,
// controller states and the command and status words between control and datapath.
// No dependencies.
package bss_pkg;

	typedef enum logic [2:0] {
		MODE_ADD_SHIFTED = 3'd0,
		MODE_ADD_IN_RANGE = 3'd1,
		MODE_OPEN = 3'd2,
		MODE_OPEN_INSERT = 3'd3,
		MODE_CLOSE = 3'd4,
		MODE_CLEAR_ALL = 3'd5,
		MODE_QUERY = 3'd6,
		MODE_NONE = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_LEVEL_FULL = 2'd1,
		ST_AT_BASE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DISP,
		S_SH_RD,
		S_SH_TST,
		S_SH_PUT,
		S_IR_RD,
		S_IR_TST,
		S_IR_PUT,
		S_OP_PUT,
		S_CL_CMP,
		S_CL_JD,
		S_CL_ER,
		S_CLR,
		S_Q_TST,
		S_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_tgt;
		logic rd_val;
		logic rd_jnl;
		logic put;
		logic step_up;
		logic step_down;
		logic mark_push;
		logic pop;
		logic erase;
		logic level_pop;
		logic clr_wr;
		logic clr_regs;
		logic set_member;
		logic set_full;
		logic set_base;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic bit_set;
		logic sh_skip;
		logic cur_zero;
		logic cur_past_top;
		logic over_lim;
		logic cur_last;
		logic val_in_map;
		logic lvl_full;
		logic lvl_base;
		logic jtop_gt_mark;
		logic out_busy;
	} sts_t;

endpackage

// ----- rtl/bss_ctrl.sv -----
// Sequencer for the subset-sum set core: walks each command through datapath steps.
// Depends on bss_pkg.
module bss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [2:0]    mode,
	input  bss_pkg::sts_t sts,
	output bss_pkg::cmd_t cmd,
	output logic          in_stall
);
	import bss_pkg::*;

	state_t state_q, state_d;
	mode_t  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			mode_q <= MODE_NONE;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_valid)
				mode_q <= mode_t'(mode);
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT, S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.cur_last) begin
					cmd.clr_regs = 1'b1;
					state_d = (state_q == S_INIT) ? S_IDLE : S_FIN;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (mode_q)
					MODE_ADD_SHIFTED: state_d = sts.sh_skip ? S_FIN : S_SH_RD;
					MODE_ADD_IN_RANGE: state_d = S_IR_RD;
					MODE_OPEN, MODE_OPEN_INSERT: begin
						if (sts.lvl_full) begin
							cmd.set_full = 1'b1;
							state_d = S_FIN;
						end else begin
							cmd.mark_push = 1'b1;
							if (mode_q == MODE_OPEN_INSERT && sts.val_in_map) begin
								cmd.rd_val = 1'b1;
								state_d = S_OP_PUT;
							end else begin
								state_d = S_FIN;
							end
						end
					end
					MODE_CLOSE: begin
						if (sts.lvl_base) begin
							cmd.set_base = 1'b1;
							state_d = S_FIN;
						end else begin
							state_d = S_CL_CMP;
						end
					end
					MODE_CLEAR_ALL: state_d = S_CLR;
					MODE_QUERY: begin
						cmd.rd_val = 1'b1;
						state_d = S_Q_TST;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_SH_RD: state_d = S_SH_TST;
			S_SH_TST: begin
				if (sts.bit_set) begin
					cmd.rd_tgt = 1'b1;
					state_d = S_SH_PUT;
				end else if (sts.cur_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.step_down = 1'b1;
					state_d = S_SH_RD;
				end
			end
			S_SH_PUT: begin
				cmd.put = !sts.bit_set;
				if (sts.cur_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.step_down = 1'b1;
					state_d = S_SH_RD;
				end
			end
			S_IR_RD: state_d = sts.cur_past_top ? S_FIN : S_IR_TST;
			S_IR_TST: begin
				if (!sts.bit_set) begin
					cmd.step_up = 1'b1;
					state_d = S_IR_RD;
				end else if (sts.over_lim) begin
					state_d = S_FIN;
				end else begin
					cmd.rd_tgt = 1'b1;
					state_d = S_IR_PUT;
				end
			end
			S_IR_PUT: begin
				cmd.put = !sts.bit_set;
				cmd.step_up = 1'b1;
				state_d = S_IR_RD;
			end
			S_OP_PUT: begin
				cmd.put = !sts.bit_set;
				state_d = S_FIN;
			end
			S_CL_CMP: begin
				if (sts.jtop_gt_mark) begin
					cmd.pop = 1'b1;
					state_d = S_CL_JD;
				end else begin
					cmd.level_pop = 1'b1;
					state_d = S_FIN;
				end
			end
			S_CL_JD: begin
				cmd.rd_jnl = 1'b1;
				state_d = S_CL_ER;
			end
			S_CL_ER: begin
				cmd.erase = sts.bit_set;
				state_d = S_CL_CMP;
			end
			S_Q_TST: begin
				cmd.set_member = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/bss_dp.sv -----
// Datapath of the subset-sum set core: sum bitmap, insert journal, level marks,
// counters and the result register. Depends on bss_pkg.
module bss_dp #(
	parameter int MAX_SUM = 4095,
	parameter int LEVELS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bss_pkg::cmd_t   cmd,
	output bss_pkg::sts_t   sts,
	input  logic [2:0]      mode,
	input  logic [11:0]     value,
	input  logic [11:0]     limit,
	input  logic [11:0]     range_low,
	input  logic [11:0]     range_high,
	input  logic            out_stall,
	output logic            out_valid,
	output logic [1:0]      status,
	output logic            member,
	output logic [12:0]     added,
	output logic [12:0]     set_size
);
	import bss_pkg::*;

	localparam int DEPTH = MAX_SUM + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam int LVW = $clog2(LEVELS);
	localparam int LTW = $clog2(LEVELS + 1);
	localparam int SW = ((CW > 12) ? CW : 12) + 1;

	logic            bm_mem [DEPTH];
	logic [AW-1:0]   jnl_mem [DEPTH];
	logic [CW-1:0]   mark_mem [LEVELS];

	logic [CW-1:0]   cur_q, jtop_q, cnt_q, added_q, mark_q;
	logic [LTW-1:0]  ltop_q;
	logic [11:0]     value_q;
	logic [AW-1:0]   lim_q, top_q, tgt_q, jrd_q;
	logic            bit_q, member_q;
	status_t         status_q;
	logic            out_valid_q, member_out_q;
	logic [1:0]      status_out_q;
	logic [12:0]     added_out_q, size_out_q;

	logic [SW-1:0]   max_w, lim_in, hi_in, lo_w, cur_sum;
	logic [CW-1:0]   cur_init, jprev;
	logic [LTW-1:0]  lprev;
	logic [AW-1:0]   rd_addr, wr_addr;
	logic            wr_en, wr_bit, jnl_room;

	assign max_w = SW'(MAX_SUM);
	assign lim_in = (SW'(limit) > max_w) ? max_w : SW'(limit);
	assign hi_in = (SW'(range_high) > max_w) ? max_w : SW'(range_high);
	assign lo_w = SW'(range_low);
	assign cur_sum = SW'(cur_q) + SW'(value_q);
	assign jprev = jtop_q - CW'(1);
	assign lprev = ltop_q - LTW'(1);
	assign jnl_room = (jtop_q <= CW'(MAX_SUM));

	always_comb begin
		unique case (mode_t'(mode))
			MODE_ADD_SHIFTED: cur_init = CW'(lim_in - SW'(value));
			MODE_ADD_IN_RANGE: cur_init = (lo_w > hi_in) ? CW'(hi_in + SW'(1)) : CW'(lo_w);
			default: cur_init = '0;
		endcase
	end

	always_comb begin
		priority if (cmd.rd_tgt)
			rd_addr = cur_sum[AW-1:0];
		else if (cmd.rd_val)
			rd_addr = AW'(value_q);
		else if (cmd.rd_jnl)
			rd_addr = jrd_q;
		else
			rd_addr = cur_q[AW-1:0];
	end

	always_comb begin
		wr_en = cmd.put | cmd.erase | cmd.clr_wr;
		wr_bit = cmd.put;
		priority if (cmd.put)
			wr_addr = tgt_q;
		else if (cmd.erase)
			wr_addr = jrd_q;
		else
			wr_addr = cur_q[AW-1:0];
	end

	// bitmap: one read and one write port, read data registered
	always_ff @(posedge clk) begin
		if (wr_en)
			bm_mem[wr_addr] <= wr_bit;
		bit_q <= bm_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.put && jnl_room)
			jnl_mem[jtop_q[AW-1:0]] <= tgt_q;
		if (cmd.pop)
			jrd_q <= jnl_mem[jprev[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.mark_push)
			mark_mem[ltop_q[LVW-1:0]] <= jtop_q;
		mark_q <= mark_mem[lprev[LVW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			lim_q <= AW'(lim_in);
			top_q <= AW'(hi_in);
		end
		if (cmd.rd_tgt)
			tgt_q <= cur_sum[AW-1:0];
		else if (cmd.rd_val)
			tgt_q <= AW'(value_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			jtop_q <= '0;
			cnt_q <= '0;
			added_q <= '0;
			ltop_q <= LTW'(1);
			member_q <= 1'b0;
			status_q <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				cur_q <= cur_init;
			else if (cmd.step_up || cmd.clr_wr)
				cur_q <= cur_q + CW'(1);
			else if (cmd.step_down)
				cur_q <= cur_q - CW'(1);

			if (cmd.clr_regs)
				jtop_q <= '0;
			else if (cmd.put && jnl_room)
				jtop_q <= jtop_q + CW'(1);
			else if (cmd.pop)
				jtop_q <= jprev;

			if (cmd.clr_regs)
				cnt_q <= '0;
			else if (cmd.put)
				cnt_q <= cnt_q + CW'(1);
			else if (cmd.erase)
				cnt_q <= cnt_q - CW'(1);

			if (cmd.load)
				added_q <= '0;
			else if (cmd.put)
				added_q <= added_q + CW'(1);

			if (cmd.clr_regs)
				ltop_q <= LTW'(1);
			else if (cmd.mark_push)
				ltop_q <= ltop_q + LTW'(1);
			else if (cmd.level_pop)
				ltop_q <= lprev;

			if (cmd.load)
				member_q <= 1'b0;
			else if (cmd.set_member)
				member_q <= sts.val_in_map & bit_q;

			if (cmd.load)
				status_q <= ST_OK;
			else if (cmd.set_full)
				status_q <= ST_LEVEL_FULL;
			else if (cmd.set_base)
				status_q <= ST_AT_BASE;

			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// result word, held while stalled
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_out_q <= status_q;
			member_out_q <= member_q;
			added_out_q <= 13'(added_q);
			size_out_q <= 13'(cnt_q);
		end
	end

	always_comb begin
		sts.bit_set = bit_q;
		sts.sh_skip = (value_q == '0) || (SW'(value_q) > SW'(lim_q));
		sts.cur_zero = (cur_q == '0);
		sts.cur_past_top = (SW'(cur_q) > SW'(top_q));
		sts.over_lim = (cur_sum > SW'(lim_q));
		sts.cur_last = (cur_q == CW'(MAX_SUM));
		sts.val_in_map = (SW'(value_q) <= max_w);
		sts.lvl_full = (ltop_q >= LTW'(LEVELS));
		sts.lvl_base = (ltop_q <= LTW'(1));
		sts.jtop_gt_mark = (jtop_q > mark_q);
		sts.out_busy = out_valid_q & out_stall;
	end

	assign out_valid = out_valid_q;
	assign status = status_out_q;
	assign member = member_out_q;
	assign added = added_out_q;
	assign set_size = size_out_q;

endmodule

// ----- rtl/backtracking_subset_sum_set_core.sv -----
// Reachable-sum set with undo journal. One word in gives one word out, and the next word
// is taken only once the previous one is finished. add_shifted scans the sums from
// limit-value down to 0 with an extra step for each sum present, add_in_range scans the
// sums in the range likewise, and close takes its steps per journal entry erased. Each
// scan step reads the sum bitmap, and a word waits in the last step while an earlier
// result is stalled. After reset and on clear_all a clearing pass sweeps the bitmap from
// 0 to MAX_SUM, during which no word is taken in. Depends on bss_pkg.
module backtracking_subset_sum_set_core #(
	parameter int MAX_SUM = 4095,
	parameter int LEVELS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [11:0] value,
	input  logic [11:0] limit,
	input  logic [11:0] range_low,
	input  logic [11:0] range_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        member,
	output logic [12:0] added,
	output logic [12:0] set_size
);
	import bss_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	bss_dp #(
		.MAX_SUM (MAX_SUM),
		.LEVELS  (LEVELS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.mode       (mode),
		.value      (value),
		.limit      (limit),
		.range_low  (range_low),
		.range_high (range_high),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.status     (status),
		.member     (member),
		.added      (added),
		.set_size   (set_size)
	);

endmodule

// ----- rtl/bss_chk.sv -----
// Port-level checks for the subset-sum set core, bound to the top level.
// Depends on bss_pkg.
module bss_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic        member,
	input logic [12:0] added
);
	import bss_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("word taken while previous one in progress");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_fail_noadd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_LEVEL_FULL || status == ST_AT_BASE) |-> added == '0)
		else $error("failed level command inserted sums");

	a_query_noadd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && member |-> added == '0)
		else $error("query result with inserted sums");

endmodule

bind backtracking_subset_sum_set_core bss_chk u_bss_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.member    (member),
	.added     (added)
);
